FILE: rtl/rlerr_pkg.sv
`timescale 1ns / 1ps
package rlerr_pkg;

    localparam int MAX_SIDE    = 512;
    localparam int QUEUE_DEPTH = 4;

    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 72;
    localparam int M_USER_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_PERCENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

    // floor(v / 10) == (v * 6554) >> 16 for v below 16384.
    localparam logic [15:0] TENTH_MUL   = 16'd6554;
    localparam int          TENTH_SHIFT = 16;
    // floor(v / 100) == (v * 167773) >> 24 for v below 2^17.
    localparam logic [17:0] HUNDREDTH_MUL   = 18'd167773;
    localparam int          HUNDREDTH_SHIFT = 24;

    typedef enum logic [1:0] {
        KIND_RECT = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [7:0]         scale_factor;
        logic signed [7:0]  tilt_percent;
        logic [POS_W-1:0]   image_width;
        logic [POS_W-1:0]   image_height;
    } cfg_t;

    // One classified run, handed from the front end to the drawing pipeline.
    typedef struct packed {
        logic             has_rect;
        logic             has_term;
        kind_t            term_kind;
        logic [15:0]      len;
        logic [15:0]      color;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } entry_t;

endpackage

FILE: rtl/rle_run_to_rect_rasterizer_unit.sv
`timescale 1ns / 1ps
// Run-length sprite rasterizer. Each request on the s_ stream is one run of an image
// (length, color, visibility, last marker); the block tracks column and row and returns
// on the m_ stream a scaled, sheared fill rectangle for each visible run, followed by a
// success or failure status when the image ends. A new run is accepted every clock the
// queue has room: the front end's column/row update is an add and compare. The drawing
// pipeline (three stages: multiplies, divide-by-100 of the shear, final adds) delivers
// one result per cycle unless stalled, so a run that yields both a rectangle and a
// status takes two transfers; a four-entry queue between the two parts absorbs that.
// Runs that are transparent and do not end the image produce nothing. There is no
// clearing pass after reset. Configuration registers are written through the cfg_ port,
// which is always ready, and must only be written while no results are outstanding.
module rle_run_to_rect_rasterizer_unit #(
    parameter int QUEUE_DEPTH = rlerr_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // run_length [15:0], run_color [31:16], visible_word [47:32]
    input  logic [rlerr_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rect_x [15:0], rect_y [31:16], rect_width [47:32], rect_height [55:48],
    // rect_color [71:56]
    output logic [rlerr_pkg::M_DATA_W-1:0]    m_tdata,
    // kind [1:0]
    output logic [rlerr_pkg::M_USER_W-1:0]    m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rlerr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlerr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rlerr_pkg::*;

    cfg_t   cfg_reg;
    logic   push, q_full, q_empty, pop;
    entry_t push_entry, pop_entry;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.scale_factor <= 8'd1;
            cfg_reg.tilt_percent <= '0;
            cfg_reg.image_width  <= POS_W'(1);
            cfg_reg.image_height <= POS_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_ORIGIN_X:     cfg_reg.origin_x     <= cfg_data;
                REG_ORIGIN_Y:     cfg_reg.origin_y     <= cfg_data;
                REG_SCALE_FACTOR: cfg_reg.scale_factor <= cfg_data[7:0];
                REG_TILT_PERCENT: cfg_reg.tilt_percent <= cfg_data[7:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[POS_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    rlerr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    rlerr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    rlerr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_entry (pop_entry),
        .q_empty   (q_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: rtl/rlerr_front.sv
`timescale 1ns / 1ps
module rlerr_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rlerr_pkg::cfg_t                 cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rlerr_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            q_full,
    output logic                            push,
    output rlerr_pkg::entry_t               push_entry
);
    import rlerr_pkg::*;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic             ended_reg, ended_next;

    logic             accept;
    logic [15:0]      len;
    logic             visible;
    logic [16:0]      sum;
    logic             geom_bad;
    logic             run_bad;
    logic             wrap;
    logic [POS_W-1:0] col_adv;
    logic [POS_W-1:0] row_adv;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        len      = s_tdata[15:0];
        visible  = |s_tdata[47:32];
        sum      = {7'b0, col_reg} + {1'b0, len};
        geom_bad = (cfg.image_width == '0) || (cfg.image_height == '0) ||
                   (int'(cfg.image_width) > MAX_SIDE) ||
                   (int'(cfg.image_height) > MAX_SIDE);
        run_bad  = (row_reg >= cfg.image_height) || (len == 16'd0) ||
                   (sum > {7'b0, cfg.image_width});
        // When the run is good the new column never exceeds the row width.
        wrap     = (sum[POS_W-1:0] == cfg.image_width);
        col_adv  = wrap ? '0 : sum[POS_W-1:0];
        row_adv  = wrap ? row_reg + 1'b1 : row_reg;

        col_next   = col_reg;
        row_next   = row_reg;
        ended_next = ended_reg;
        push       = 1'b0;

        push_entry.has_rect  = 1'b0;
        push_entry.has_term  = 1'b0;
        push_entry.term_kind = KIND_FAIL;
        push_entry.len       = len;
        push_entry.color     = s_tdata[31:16];
        push_entry.col       = col_reg;
        push_entry.row       = row_reg;

        if (accept) begin
            if (ended_reg) begin
                if (s_tlast) begin
                    col_next   = '0;
                    row_next   = '0;
                    ended_next = 1'b0;
                end
            end else if (geom_bad || run_bad) begin
                push_entry.has_term = 1'b1;
                col_next            = '0;
                row_next            = '0;
                ended_next          = !s_tlast;
            end else begin
                push_entry.has_rect = visible;
                if (row_adv == cfg.image_height) begin
                    push_entry.has_term  = 1'b1;
                    push_entry.term_kind = KIND_OK;
                    col_next             = '0;
                    row_next             = '0;
                    ended_next           = !s_tlast;
                end else if (s_tlast) begin
                    push_entry.has_term = 1'b1;
                    col_next            = '0;
                    row_next            = '0;
                end else begin
                    col_next = col_adv;
                    row_next = row_adv;
                end
            end
            push = push_entry.has_rect || push_entry.has_term;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            ended_reg <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            ended_reg <= ended_next;
        end
    end

endmodule

FILE: rtl/rlerr_queue.sv
`timescale 1ns / 1ps
module rlerr_queue #(
    parameter int DEPTH = rlerr_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rlerr_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output rlerr_pkg::entry_t pop_entry,
    output logic              empty
);
    import rlerr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign empty     = (cnt_reg == '0);
    assign pop_entry = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/rlerr_back.sv
`timescale 1ns / 1ps
module rlerr_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rlerr_pkg::cfg_t                 cfg,
    input  rlerr_pkg::entry_t               pop_entry,
    input  logic                            q_empty,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rlerr_pkg::M_DATA_W-1:0]  m_tdata,
    output logic [rlerr_pkg::M_USER_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import rlerr_pkg::*;

    // Anchor row height*9/10, recomputed from the register every cycle.
    logic [13:0]      h9;
    logic [29:0]      anchor_prod;
    logic [POS_W-1:0] anchor_reg;

    // Stage A: products.
    logic               a_v_reg;
    logic               a_rect_reg, a_term_reg;
    kind_t              a_kind_reg;
    logic [15:0]        a_color_reg, a_w_reg, a_colx_reg, a_rowy_reg;
    logic signed [18:0] a_prod_reg;
    logic signed [10:0] diff;
    logic signed [18:0] tilt_prod;
    logic [17:0]        col_scaled, row_scaled;
    logic [23:0]        len_scaled;

    // Stage B: division of the shear by 100.
    logic               b_v_reg;
    logic               b_rect_reg, b_term_reg;
    kind_t              b_kind_reg;
    logic [15:0]        b_color_reg, b_w_reg, b_colx_reg, b_rowy_reg;
    logic               b_neg_reg;
    logic [35:0]        b_qp_reg;
    logic [18:0]        mag_full;

    // Output slot: a pending rectangle and/or a pending status.
    logic               slot_v_reg;
    logic               slot_rect_reg, slot_term_reg;
    kind_t              slot_kind_reg;
    logic [15:0]        slot_x_reg, slot_y_reg, slot_w_reg, slot_color_reg;
    logic [7:0]         slot_h_reg;
    logic [10:0]        quot;
    logic [15:0]        shift;
    logic               out_hs, slot_done, en;

    assign h9          = {1'b0, cfg.image_height, 3'b0} + {4'b0, cfg.image_height};
    assign anchor_prod = h9 * TENTH_MUL;

    always_ff @(posedge aclk) begin
        anchor_reg <= anchor_prod[TENTH_SHIFT +: POS_W];
    end

    assign out_hs    = m_tvalid && m_tready;
    assign slot_done = out_hs && m_tlast;
    assign en        = !slot_v_reg || slot_done;
    assign pop       = en && !q_empty;

    always_comb begin
        diff       = $signed({1'b0, pop_entry.row}) - $signed({1'b0, anchor_reg});
        tilt_prod  = diff * cfg.tilt_percent;
        col_scaled = pop_entry.col * cfg.scale_factor;
        row_scaled = pop_entry.row * cfg.scale_factor;
        len_scaled = pop_entry.len * cfg.scale_factor;
        mag_full   = a_prod_reg[18] ? 19'(-a_prod_reg) : 19'(a_prod_reg);
        quot       = b_qp_reg[HUNDREDTH_SHIFT +: 11];
        shift      = b_neg_reg ? 16'(-{5'b0, quot}) : {5'b0, quot};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            slot_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg    <= !q_empty;
            b_v_reg    <= a_v_reg;
            slot_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_rect_reg  <= pop_entry.has_rect;
            a_term_reg  <= pop_entry.has_term;
            a_kind_reg  <= pop_entry.term_kind;
            a_color_reg <= pop_entry.color;
            a_w_reg     <= len_scaled[15:0];
            a_colx_reg  <= col_scaled[15:0];
            a_rowy_reg  <= row_scaled[15:0];
            a_prod_reg  <= tilt_prod;

            b_rect_reg  <= a_rect_reg;
            b_term_reg  <= a_term_reg;
            b_kind_reg  <= a_kind_reg;
            b_color_reg <= a_color_reg;
            b_w_reg     <= a_w_reg;
            b_colx_reg  <= a_colx_reg;
            b_rowy_reg  <= a_rowy_reg;
            b_neg_reg   <= a_prod_reg[18];
            b_qp_reg    <= mag_full[17:0] * HUNDREDTH_MUL;

            slot_term_reg  <= b_term_reg;
            slot_kind_reg  <= b_kind_reg;
            slot_x_reg     <= cfg.origin_x + shift + b_colx_reg;
            slot_y_reg     <= cfg.origin_y + b_rowy_reg;
            slot_w_reg     <= b_w_reg;
            slot_h_reg     <= cfg.scale_factor;
            slot_color_reg <= b_color_reg;
        end
    end

    // The rectangle goes out first; once it is taken only the status remains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_rect_reg <= 1'b0;
        end else if (en) begin
            slot_rect_reg <= b_v_reg && b_rect_reg;
        end else if (out_hs) begin
            slot_rect_reg <= 1'b0;
        end
    end

    always_comb begin
        m_tvalid = slot_v_reg;
        if (slot_rect_reg) begin
            m_tuser = KIND_RECT;
            m_tdata = {slot_color_reg, slot_h_reg, slot_w_reg, slot_y_reg, slot_x_reg};
            m_tlast = !slot_term_reg;
        end else begin
            m_tuser = slot_kind_reg;
            m_tdata = '0;
            m_tlast = 1'b1;
        end
    end

endmodule

FILE: rtl/rlerr_checker.sv
`timescale 1ns / 1ps
module rlerr_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rlerr_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [rlerr_pkg::M_USER_W-1:0]  m_tuser,
    input logic                            m_tlast
);
    import rlerr_pkg::*;

    // A stalled result holds still.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // A status result closes the request and carries no rectangle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_RECT) |-> m_tlast && (m_tdata == '0))
        else $error("status result is not last or has nonzero data");

    // A rectangle without tlast is followed at once by its status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == KIND_RECT) && !m_tlast |=>
        m_tvalid && (m_tuser != KIND_RECT))
        else $error("rectangle not followed by status");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rle_run_to_rect_rasterizer_unit rlerr_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
